[hdl/ibsc_pkg.sv]
// Shared types and constants for the IMU bias and scale compensation block.
// Used by the controller, the datapath and the top level; no dependencies.
package ibsc_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int VEC_BITS       = SAMPLE_BITS + 1;
    localparam int PROD_BITS      = COEF_BITS + VEC_BITS;
    localparam int MAC_BITS       = PROD_BITS + 2;
    localparam int REG_BITS       = 48;
    localparam int IDX_BITS       = 3;
    localparam int DIV_STEPS      = VEC_BITS;
    localparam int IN_DATA_BITS   = 6 * SAMPLE_BITS;
    localparam int OUT_DATA_BITS  = 9 * SAMPLE_BITS;
    localparam int IN_USER_BITS   = 3;

    // Register indexes
    localparam logic [IDX_BITS-1:0] REG_ACC_ROW0   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_ACC_ROW1   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_ACC_ROW2   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_GYRO_ROW0  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_GYRO_ROW1  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_GYRO_ROW2  = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_ACC_OFFSET = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_GYRO_PRESET = 3'd7;

    // Item op codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;

    // Reset values of the matrix rows (identity in Q2.14)
    localparam logic [REG_BITS-1:0] ROW0_RESET = 48'h0000_0000_4000;
    localparam logic [REG_BITS-1:0] ROW1_RESET = 48'h0000_4000_0000;
    localparam logic [REG_BITS-1:0] ROW2_RESET = 48'h4000_0000_0000;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       div_step;
        logic       div_write;
        logic [1:0] axis;
        logic       mac_mul;
        logic       mac_acc;
        logic [2:0] out_idx;
        logic [1:0] col;
        logic       out_load;
    } ibsc_cmd_t;

    typedef struct packed {
        logic need_div;
    } ibsc_status_t;

endpackage

[hdl/imu_bias_scale_compensation.sv]
// Top level of the IMU bias and scale compensation block.
// Instantiates ibsc_ctrl and ibsc_datapath; uses ibsc_pkg.
//
// One item is taken at a time. An item runs through load, decide, the
// matrix products and the output hand-off; an item with estimation on that
// is neither a start nor a load first runs the three gyro bias divisions,
// each one quotient bit a cycle in a restoring divider. The eighteen matrix
// products share one multiplier with a multiply and an accumulate step each.
// The input opens again in the same cycle as the result is posted. A new
// item is taken once the previous result sits in the output register, even
// while that result is still waiting.
module imu_bias_scale_compensation #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z (16 bits each)
    input  logic [ibsc_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // op [1:0], estimate [2]
    input  logic [ibsc_pkg::IN_USER_BITS-1:0]   s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // acc_out_x/y/z, rate_out_x/y/z, bias_out_x/y/z (16 bits each)
    output logic [ibsc_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input  logic                                cfg_we,
    input  logic [ibsc_pkg::IDX_BITS-1:0]       cfg_index,
    input  logic [ibsc_pkg::REG_BITS-1:0]       cfg_wdata
);
    ibsc_pkg::ibsc_cmd_t    cmd;
    ibsc_pkg::ibsc_status_t status;

    ibsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ibsc_datapath #(.COUNT_BITS(COUNT_BITS)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

    // A result never appears the cycle after an item is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result raised right after item accept");

    // A new result is only posted while no item is being taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result posted while input was open");

endmodule

[hdl/ibsc_datapath.sv]
// Datapath: configuration registers, bias and count state, serial divider,
// shared multiply-accumulate unit and output register. Uses ibsc_pkg.
module ibsc_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ibsc_pkg::ibsc_cmd_t                  cmd,
    output ibsc_pkg::ibsc_status_t               status,
    input  logic [ibsc_pkg::IN_DATA_BITS-1:0]    s_tdata,
    input  logic [ibsc_pkg::IN_USER_BITS-1:0]    s_tuser,
    input  logic                                 cfg_we,
    input  logic [ibsc_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [ibsc_pkg::REG_BITS-1:0]        cfg_wdata,
    output logic [ibsc_pkg::OUT_DATA_BITS-1:0]   m_tdata
);
    localparam int SB = ibsc_pkg::SAMPLE_BITS;
    localparam int VB = ibsc_pkg::VEC_BITS;
    localparam int PB = ibsc_pkg::PROD_BITS;
    localparam int MB = ibsc_pkg::MAC_BITS;

    logic [ibsc_pkg::REG_BITS-1:0] row_reg [6];
    logic [ibsc_pkg::REG_BITS-1:0] acc_off_reg;
    logic [ibsc_pkg::REG_BITS-1:0] preset_reg;

    logic signed [SB-1:0] bias_reg [3];
    logic [COUNT_BITS-1:0] count_reg;
    logic [1:0]           op_reg;
    logic                 est_reg;
    logic signed [SB-1:0] acc_in_reg [3];
    logic signed [SB-1:0] rate_in_reg [3];

    logic [COUNT_BITS-1:0] rem_reg;
    logic [VB-1:0]         quo_reg;
    logic                  neg_reg;

    logic signed [PB-1:0] prod_reg;
    logic signed [MB-1:0] mac_reg;
    logic signed [SB-1:0] res_reg [6];

    function automatic logic signed [SB-1:0] sat_mac(input logic signed [MB-1:0] v);
        logic signed [MB-1:0] s;
        s = v >>> ibsc_pkg::COEF_FRAC_BITS;
        if (s > $signed({{(MB-SB+1){1'b0}}, {(SB-1){1'b1}}}))
            return {1'b0, {(SB-1){1'b1}}};
        else if (s < $signed({{(MB-SB+1){1'b1}}, {(SB-1){1'b0}}}))
            return {1'b1, {(SB-1){1'b0}}};
        else
            return s[SB-1:0];
    endfunction

    // Select operands for the current axis and matrix element
    logic signed [SB-1:0] bias_sel, rate_sel;
    logic signed [VB-1:0] vec_sel, div_sum;
    logic signed [ibsc_pkg::COEF_BITS-1:0] coef_sel;
    logic [1:0] vcol;

    always_comb begin
        case (cmd.axis)
            2'd0:    begin bias_sel = bias_reg[0]; rate_sel = rate_in_reg[0]; end
            2'd1:    begin bias_sel = bias_reg[1]; rate_sel = rate_in_reg[1]; end
            default: begin bias_sel = bias_reg[2]; rate_sel = rate_in_reg[2]; end
        endcase
        div_sum = VB'(bias_sel) + VB'(rate_sel);
        vcol = cmd.col;
        case (vcol)
            2'd0: vec_sel = (cmd.out_idx < 3'd3)
                ? VB'(acc_in_reg[0]) + VB'($signed(acc_off_reg[15:0]))
                : VB'(rate_in_reg[0]) + VB'(bias_reg[0]);
            2'd1: vec_sel = (cmd.out_idx < 3'd3)
                ? VB'(acc_in_reg[1]) + VB'($signed(acc_off_reg[31:16]))
                : VB'(rate_in_reg[1]) + VB'(bias_reg[1]);
            default: vec_sel = (cmd.out_idx < 3'd3)
                ? VB'(acc_in_reg[2]) + VB'($signed(acc_off_reg[47:32]))
                : VB'(rate_in_reg[2]) + VB'(bias_reg[2]);
        endcase
        coef_sel = $signed(row_reg[(cmd.out_idx < 3'd6) ? cmd.out_idx : 3'd5]
                           [16 * cmd.col +: 16]);
    end

    // Divider step, bias write-back and accumulate values
    logic [COUNT_BITS:0]    rem_sh;
    logic signed [VB:0]     quo_s;
    logic signed [VB+1:0]   new_bias;
    logic signed [SB-1:0]   new_bias_sat;
    logic signed [MB-1:0]   mac_next;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[VB-1]};
        quo_s  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        new_bias = (VB+2)'(bias_sel) - (VB+2)'(quo_s);
        if (new_bias > $signed((VB+2)'(2**(SB-1) - 1)))
            new_bias_sat = {1'b0, {(SB-1){1'b1}}};
        else if (new_bias < $signed(-(VB+2)'(2**(SB-1))))
            new_bias_sat = {1'b1, {(SB-1){1'b0}}};
        else
            new_bias_sat = new_bias[SB-1:0];
        mac_next = ((cmd.col == 2'd0) ? '0 : mac_reg) + MB'(prod_reg);
    end

    assign status.need_div = (op_reg != ibsc_pkg::OP_START) &&
                             (op_reg != ibsc_pkg::OP_LOAD) && est_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0]  <= ibsc_pkg::ROW0_RESET;
            row_reg[1]  <= ibsc_pkg::ROW1_RESET;
            row_reg[2]  <= ibsc_pkg::ROW2_RESET;
            row_reg[3]  <= ibsc_pkg::ROW0_RESET;
            row_reg[4]  <= ibsc_pkg::ROW1_RESET;
            row_reg[5]  <= ibsc_pkg::ROW2_RESET;
            acc_off_reg <= '0;
            preset_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                ibsc_pkg::REG_ACC_ROW0:    row_reg[0]  <= cfg_wdata;
                ibsc_pkg::REG_ACC_ROW1:    row_reg[1]  <= cfg_wdata;
                ibsc_pkg::REG_ACC_ROW2:    row_reg[2]  <= cfg_wdata;
                ibsc_pkg::REG_GYRO_ROW0:   row_reg[3]  <= cfg_wdata;
                ibsc_pkg::REG_GYRO_ROW1:   row_reg[4]  <= cfg_wdata;
                ibsc_pkg::REG_GYRO_ROW2:   row_reg[5]  <= cfg_wdata;
                ibsc_pkg::REG_ACC_OFFSET:  acc_off_reg <= cfg_wdata;
                ibsc_pkg::REG_GYRO_PRESET: preset_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Bias and count state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg[0] <= '0;
            bias_reg[1] <= '0;
            bias_reg[2] <= '0;
            count_reg   <= '0;
        end else if (cmd.load) begin
            if (s_tuser[1:0] == ibsc_pkg::OP_START) begin
                for (int i = 0; i < 3; i++) begin
                    if (s_tdata[48+16*i +: 16] == 16'h8000)
                        bias_reg[i] <= {1'b0, {(SB-1){1'b1}}};
                    else
                        bias_reg[i] <= -$signed(s_tdata[48+16*i +: 16]);
                end
                count_reg <= '0;
            end else if (s_tuser[1:0] == ibsc_pkg::OP_LOAD) begin
                for (int i = 0; i < 3; i++)
                    bias_reg[i] <= $signed(preset_reg[16*i +: 16]);
            end else if (s_tuser[2] && (count_reg != '1)) begin
                count_reg <= count_reg + 1'b1;
            end
        end else if (cmd.div_write) begin
            case (cmd.axis)
                2'd0:    bias_reg[0] <= new_bias_sat;
                2'd1:    bias_reg[1] <= new_bias_sat;
                default: bias_reg[2] <= new_bias_sat;
            endcase
        end
    end

    // Item latch, divider, multiply-accumulate and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg  <= ibsc_pkg::OP_SAMPLE;
            est_reg <= 1'b0;
        end else if (cmd.load) begin
            op_reg  <= s_tuser[1:0];
            est_reg <= s_tuser[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                acc_in_reg[i]  <= $signed(s_tdata[16*i +: 16]);
                rate_in_reg[i] <= $signed(s_tdata[48+16*i +: 16]);
            end
        end
        if (cmd.div_start) begin
            neg_reg <= div_sum[VB-1];
            quo_reg <= div_sum[VB-1] ? VB'(-div_sum) : VB'(div_sum);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_sh >= {1'b0, count_reg}) begin
                rem_reg <= COUNT_BITS'(rem_sh - {1'b0, count_reg});
                quo_reg <= {quo_reg[VB-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[COUNT_BITS-1:0];
                quo_reg <= {quo_reg[VB-2:0], 1'b0};
            end
        end
        if (cmd.mac_mul)
            prod_reg <= coef_sel * vec_sel;
        if (cmd.mac_acc) begin
            mac_reg <= mac_next;
            if (cmd.col == 2'd2) begin
                case (cmd.out_idx)
                    3'd0:    res_reg[0] <= sat_mac(mac_next);
                    3'd1:    res_reg[1] <= sat_mac(mac_next);
                    3'd2:    res_reg[2] <= sat_mac(mac_next);
                    3'd3:    res_reg[3] <= sat_mac(mac_next);
                    3'd4:    res_reg[4] <= sat_mac(mac_next);
                    default: res_reg[5] <= sat_mac(mac_next);
                endcase
            end
        end
        if (cmd.out_load)
            m_tdata <= {bias_reg[2], bias_reg[1], bias_reg[0], res_reg[5], res_reg[4],
                        res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
    end

endmodule

[hdl/ibsc_ctrl.sv]
// Controller: sequences item load, three serial divisions when estimation runs,
// eighteen multiply-accumulate steps and the output hand-off. Uses ibsc_pkg.
module ibsc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  ibsc_pkg::ibsc_status_t status,
    output ibsc_pkg::ibsc_cmd_t    cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_DECIDE, ST_DIV_START, ST_DIV_STEP, ST_DIV_WRITE,
        ST_MUL, ST_ACC, ST_WAIT_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] axis_reg;
    logic [4:0] step_reg;
    logic [2:0] out_reg;
    logic [1:0] col_reg;
    logic       m_tvalid_reg;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Decode commands from the current state
    always_comb begin
        cmd           = '0;
        cmd.axis      = axis_reg;
        cmd.out_idx   = out_reg;
        cmd.col       = col_reg;
        cmd.load      = (state_reg == ST_IDLE) && s_tvalid;
        cmd.div_start = (state_reg == ST_DIV_START);
        cmd.div_step  = (state_reg == ST_DIV_STEP);
        cmd.div_write = (state_reg == ST_DIV_WRITE);
        cmd.mac_mul   = (state_reg == ST_MUL);
        cmd.mac_acc   = (state_reg == ST_ACC);
        cmd.out_load  = (state_reg == ST_WAIT_OUT) && out_free;
    end

    // Advance the sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            axis_reg     <= '0;
            step_reg     <= '0;
            out_reg      <= '0;
            col_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Post a result once the output register is free, drop it once taken
            if ((state_reg == ST_WAIT_OUT) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid)
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    axis_reg <= '0;
                    out_reg  <= '0;
                    col_reg  <= '0;
                    state_reg <= status.need_div ? ST_DIV_START : ST_MUL;
                end
                ST_DIV_START: begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV_STEP;
                end
                ST_DIV_STEP: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'(ibsc_pkg::DIV_STEPS - 1))
                        state_reg <= ST_DIV_WRITE;
                end
                ST_DIV_WRITE: begin
                    if (axis_reg == 2'd2) begin
                        state_reg <= ST_MUL;
                    end else begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= ST_DIV_START;
                    end
                end
                ST_MUL: state_reg <= ST_ACC;
                ST_ACC: begin
                    if (col_reg != 2'd2) begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end else if (out_reg != 3'd5) begin
                        col_reg   <= '0;
                        out_reg   <= out_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_WAIT_OUT;
                    end
                end
                ST_WAIT_OUT: begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[sim/imu_bias_scale_compensation_tb.sv]
// Testbench for imu_bias_scale_compensation: drives IMU sample items and register
// writes, predicts each compensated sample in-line and compares field by field.
// Depends on ibsc_pkg and the RTL of the block only.
module imu_bias_scale_compensation_tb;

    localparam int CNT_MAX = 65535;
    localparam int IDX_W   = ibsc_pkg::IDX_BITS;
    localparam int REG_W   = ibsc_pkg::REG_BITS;
    localparam int OUT_W   = ibsc_pkg::OUT_DATA_BITS;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic        est;
        logic [15:0] ax, ay, az, gx, gy, gz;
    } imu_item_t;

    localparam int ITEM_BITS = $bits(imu_item_t);

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ibsc_pkg::IN_DATA_BITS-1:0] s_tdata = '0;
    logic [ibsc_pkg::IN_USER_BITS-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_wdata = '0;

    imu_bias_scale_compensation i_dut (.*);

    // Predictor state
    logic [REG_W-1:0] regs_q [8];
    logic signed [15:0] bias_q [3];
    int unsigned count_q;

    logic [OUT_W-1:0] expected_samples [$];
    int errors = 0;
    int results_seen = 0;
    int n_starts = 0, n_loads = 0, n_est = 0;
    bit quiet_tail = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #400_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic longint coef(logic [REG_W-1:0] row, int c);
        logic signed [15:0] w;
        w = row[16*c +: 16];
        return longint'(w);
    endfunction

    // Row times vector, floored by the fraction bits and saturated
    function automatic logic signed [15:0] row_dot(logic [REG_W-1:0] row, longint v0,
                                                   longint v1, longint v2);
        longint acc;
        acc = coef(row, 0) * v0 + coef(row, 1) * v1 + coef(row, 2) * v2;
        return clamp16(acc >>> ibsc_pkg::COEF_FRAC_BITS);
    endfunction

    // Advance the bias state and build the compensated result for one item
    function automatic logic [OUT_W-1:0] compensate(imu_item_t it);
        logic [OUT_W-1:0] r;
        longint raw_a [3], raw_g [3], va [3], vg [3], q;
        logic signed [15:0] sa, sg;
        for (int i = 0; i < 3; i++) begin
            sa = (i == 0) ? it.ax : (i == 1) ? it.ay : it.az;
            sg = (i == 0) ? it.gx : (i == 1) ? it.gy : it.gz;
            raw_a[i] = sa;
            raw_g[i] = sg;
        end
        if (it.op == ibsc_pkg::OP_START) begin
            for (int i = 0; i < 3; i++) bias_q[i] = clamp16(-raw_g[i]);
            count_q = 0;
        end else if (it.op == ibsc_pkg::OP_LOAD) begin
            for (int i = 0; i < 3; i++)
                bias_q[i] = regs_q[ibsc_pkg::REG_GYRO_PRESET][16*i +: 16];
        end else if (it.est) begin
            if (count_q < CNT_MAX) count_q++;
            for (int i = 0; i < 3; i++) begin
                q = (longint'(bias_q[i]) + raw_g[i]) / longint'(count_q);
                bias_q[i] = clamp16(longint'(bias_q[i]) - q);
            end
        end
        for (int i = 0; i < 3; i++) begin
            sa = regs_q[ibsc_pkg::REG_ACC_OFFSET][16*i +: 16];
            va[i] = raw_a[i] + sa;
            vg[i] = raw_g[i] + bias_q[i];
        end
        for (int i = 0; i < 3; i++) begin
            r[16*i +: 16] = row_dot(regs_q[IDX_W'(ibsc_pkg::REG_ACC_ROW0 + i)],
                                    va[0], va[1], va[2]);
            r[16*(3+i) +: 16] = row_dot(regs_q[IDX_W'(ibsc_pkg::REG_GYRO_ROW0 + i)],
                                        vg[0], vg[1], vg[2]);
            r[16*(6+i) +: 16] = bias_q[i];
        end
        return r;
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        regs_q[idx] = val;
    endtask

    // Drop the input, hold until every expected item is back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    task automatic send_item(imu_item_t it, logic [OUT_W-1:0] typed_in, bit has_typed);
        logic [OUT_W-1:0] pred;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tdata <= {it.gz, it.gy, it.gx, it.az, it.ay, it.ax};
        s_tuser <= {it.est, it.op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = compensate(it);
        if (it.op == ibsc_pkg::OP_START) n_starts++;
        if (it.op == ibsc_pkg::OP_LOAD) n_loads++;
        if (it.op != ibsc_pkg::OP_START && it.op != ibsc_pkg::OP_LOAD && it.est) n_est++;
        if (has_typed && typed_in != pred) begin
            errors++;
            if (errors <= 10)
                $display("table row disagrees with predictor: %h vs %h", typed_in, pred);
        end
        expected_samples.push_back(pred);
        @(negedge aclk);
    endtask

    function automatic imu_item_t random_item();
        imu_item_t it;
        int k;
        it = imu_item_t'(ITEM_BITS'({$urandom, $urandom, $urandom, $urandom}));
        k = $urandom_range(0, 99);
        // mostly estimation runs, with some starts, loads, plain samples, op 3
        it.op = (k < 4) ? ibsc_pkg::OP_START : (k < 7) ? ibsc_pkg::OP_LOAD
              : (k < 9) ? OP_SPARE : ibsc_pkg::OP_SAMPLE;
        it.est = ($urandom_range(0, 9) < 8);
        if ($urandom_range(0, 3) != 0) begin
            // small gyro values within the 12-bit signed range keep the average meaningful
            it.gx = 16'($signed(12'($urandom)));
            it.gy = 16'($signed(12'($urandom)));
            it.gz = 16'($signed(12'($urandom)));
        end
        return it;
    endfunction

    function automatic logic [REG_W-1:0] random_row(int r);
        logic [REG_W-1:0] v;
        v = REG_W'({$urandom, $urandom});
        if ($urandom_range(0, 2) != 0) begin
            v = '0;
            for (int c = 0; c < 3; c++)
                v[16*c +: 16] = (c == r) ? 16'(16384 + $urandom_range(0, 1024) - 512)
                                         : 16'($signed(10'($urandom)));
        end
        return v;
    endfunction

    // Output side: random stalls, compare against the oldest expectation
    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_samples.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = expected_samples.pop_front();
                for (int f = 0; f < 9; f++)
                    if (want[16*f +: 16] !== m_tdata[16*f +: 16]) begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d field %0d: expected %0d got %0d",
                                     results_seen, f, $signed(want[16*f +: 16]),
                                     $signed(m_tdata[16*f +: 16]));
                    end
            end
        end
    end

    int stall_left = 0;
    always @(negedge aclk) begin
        if (quiet_tail) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Directed table: op, est, samples, typed expectation where obvious
    typedef struct {
        imu_item_t it;
        bit typed;
        logic [OUT_W-1:0] res;
    } table_row_t;

    table_row_t dir_rows [$];

    function automatic imu_item_t mk(logic [1:0] op, logic est, int ax, int ay, int az,
                                     int gx, int gy, int gz);
        imu_item_t it;
        it.op = op; it.est = est;
        it.ax = ax[15:0]; it.ay = ay[15:0]; it.az = az[15:0];
        it.gx = gx[15:0]; it.gy = gy[15:0]; it.gz = gz[15:0];
        return it;
    endfunction

    initial begin
        imu_item_t it;
        regs_q[0] = ibsc_pkg::ROW0_RESET; regs_q[1] = ibsc_pkg::ROW1_RESET;
        regs_q[2] = ibsc_pkg::ROW2_RESET;
        regs_q[3] = ibsc_pkg::ROW0_RESET; regs_q[4] = ibsc_pkg::ROW1_RESET;
        regs_q[5] = ibsc_pkg::ROW2_RESET;
        regs_q[6] = '0; regs_q[7] = '0;
        for (int i = 0; i < 3; i++) bias_q[i] = 0;
        count_q = 0;

        // identity after reset: extremes pass straight through
        dir_rows.push_back('{mk(ibsc_pkg::OP_SAMPLE, 0, 32767, -32768, 0, -32768, 32767, 1), 1,
            {16'h0, 16'h0, 16'h0, 16'h0001, 16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h7fff}});
        dir_rows.push_back('{mk(ibsc_pkg::OP_SAMPLE, 0, -1, 1, -1, 0, 0, 0), 1,
            {48'h0, 48'h0, 16'hffff, 16'h0001, 16'hffff}});
        // start with most negative rate saturates the bias to max positive
        dir_rows.push_back('{mk(ibsc_pkg::OP_START, 1, 0, 0, 0, -32768, 32767, 5), 1,
            {16'hfffb, 16'h8001, 16'h7fff, 16'h0000, 16'h0000, 16'hffff, 48'h0}});
        dir_rows.push_back('{mk(ibsc_pkg::OP_SAMPLE, 1, 100, 200, 300, 10, 20, 30), 0, '0});
        dir_rows.push_back('{mk(ibsc_pkg::OP_SAMPLE, 1, -100, -200, -300, -10, 20, -30), 0,
                             '0});
        dir_rows.push_back('{mk(ibsc_pkg::OP_SAMPLE, 1, 32767, 32767, 32767, 32767, 32767,
                                32767), 0, '0});
        dir_rows.push_back('{mk(ibsc_pkg::OP_SAMPLE, 1, -32768, -32768, -32768, -32768,
                                -32768, -32768), 0, '0});
        dir_rows.push_back('{mk(OP_SPARE, 1, 5, 6, 7, 8, 9, 10), 0, '0});
        dir_rows.push_back('{mk(OP_SPARE, 0, 5, 6, 7, 8, 9, 10), 0, '0});
        // load of the reset preset clears the bias
        dir_rows.push_back('{mk(ibsc_pkg::OP_LOAD, 1, 3, 4, 5, 6, 7, 8), 1,
            {48'h0, 16'h0008, 16'h0007, 16'h0006, 16'h0005, 16'h0004, 16'h0003}});
        dir_rows.push_back('{mk(ibsc_pkg::OP_START, 0, 0, 0, 0, 32767, -1, 0), 0, '0});
        dir_rows.push_back('{mk(ibsc_pkg::OP_SAMPLE, 0, 0, 0, 0, 1, 1, 1), 0, '0});

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].res, dir_rows[i].typed);
        drain();

        // extremes of the registers: all-negative matrices and offsets
        for (int r = 0; r < 8; r++) write_reg(r[IDX_W-1:0], 48'h8000_8000_8000);
        send_item(mk(ibsc_pkg::OP_LOAD, 0, 32767, 32767, 32767, 32767, 32767, 32767), '0, 0);
        send_item(mk(ibsc_pkg::OP_SAMPLE, 0, -32768, -32768, -32768, -32768, -32768, -32768),
                  '0, 0);
        drain();
        for (int r = 0; r < 8; r++) write_reg(r[IDX_W-1:0], 48'h7fff_7fff_7fff);
        send_item(mk(ibsc_pkg::OP_LOAD, 1, 32767, 32767, 32767, 32767, 32767, 32767), '0, 0);
        send_item(mk(ibsc_pkg::OP_SAMPLE, 0, -32768, -32768, -32768, 1, 2, 3), '0, 0);
        drain();

        // random phases, each with fresh register settings
        for (int ph = 0; ph < 6; ph++) begin
            for (int r = 0; r < 3; r++) begin
                write_reg(IDX_W'(ibsc_pkg::REG_ACC_ROW0 + r), random_row(r));
                write_reg(IDX_W'(ibsc_pkg::REG_GYRO_ROW0 + r), random_row(r));
            end
            write_reg(ibsc_pkg::REG_ACC_OFFSET,
                      ($urandom_range(0, 1) != 0) ? REG_W'({$urandom, $urandom})
                      : {16'($signed(8'($urandom))), 16'($signed(8'($urandom))),
                         16'($signed(8'($urandom)))});
            write_reg(ibsc_pkg::REG_GYRO_PRESET, REG_W'({$urandom, $urandom}));
            if (ph == 5) quiet_tail = 1;
            for (int n = 0; n < 200; n++) begin
                it = random_item();
                send_item(it, '0, 0);
            end
            drain();
        end

        $display("covered %0d results: %0d starts, %0d loads, %0d estimating samples",
                 results_seen, n_starts, n_loads, n_est);
        $display("over eight register setups including all-min and all-max extremes");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("mismatches: %0d", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
